[hdl/ubxp_pkg.sv]
// Shared types and constants for the binary GPS frame parser.
`timescale 1ns / 1ps

package ubxp_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'd181;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'd98;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd512;

  // Event kinds
  localparam logic [1:0] EVT_PAYLOAD  = 2'd0;
  localparam logic [1:0] EVT_GOOD     = 2'd1;
  localparam logic [1:0] EVT_BAD_SUM  = 2'd2;
  localparam logic [1:0] EVT_LEN_REJ  = 2'd3;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  msg_cls;
    logic [7:0]  msg_ident;
    logic [15:0] frame_length;
    logic [15:0] byte_index;
    logic [7:0]  payload_value;
    logic        frame_last;
  } evt_t;

endpackage

[hdl/ubxp_ifs.sv]
// Valid/ready channel interfaces for received bytes and parser events.
`timescale 1ns / 1ps

interface ubxp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ubxp_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  msg_cls;
  logic [7:0]  msg_ident;
  logic [15:0] frame_length;
  logic [15:0] byte_index;
  logic [7:0]  payload_value;
  logic        frame_last;

  modport source (output valid, output event_kind, output msg_cls, output msg_ident,
                  output frame_length, output byte_index, output payload_value,
                  output frame_last, input ready);
  modport sink (input valid, input event_kind, input msg_cls, input msg_ident,
                input frame_length, input byte_index, input payload_value,
                input frame_last, output ready);
endinterface

[hdl/ubxp_cfg_regs.sv]
// APB-style configuration registers: sync bytes and payload length limit.
`timescale 1ns / 1ps

module ubxp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ubxp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ubxp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ubxp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output ubxp_pkg::cfg_t                 cfg
);
  import ubxp_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= SYNC_FIRST_RST;
      cfg.sync_second <= SYNC_SECOND_RST;
      cfg.max_payload <= MAX_PAYLOAD_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SYNC_FIRST:  cfg.sync_first  <= pwdata[7:0];
        REG_SYNC_SECOND: cfg.sync_second <= pwdata[7:0];
        REG_MAX_PAYLOAD: cfg.max_payload <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SYNC_FIRST:  prdata = {24'd0, cfg.sync_first};
      REG_SYNC_SECOND: prdata = {24'd0, cfg.sync_second};
      REG_MAX_PAYLOAD: prdata = {16'd0, cfg.max_payload};
      default:         prdata = '0;
    endcase
  end

endmodule

[hdl/ubxp_core.sv]
// Frame state machine, Fletcher checksum and per-byte event generation.
`timescale 1ns / 1ps

module ubxp_core (
  input  logic           clk,
  input  logic           rst,
  input  ubxp_pkg::cfg_t cfg,
  input  logic           step,
  input  logic [7:0]     rx_byte,
  output logic           res_valid,
  output ubxp_pkg::evt_t res
);
  import ubxp_pkg::*;

  typedef enum logic [3:0] {
    HUNT     = 4'd0,
    SYNC2    = 4'd1,
    CLASS    = 4'd2,
    IDENT    = 4'd3,
    LEN_LO   = 4'd4,
    LEN_HI   = 4'd5,
    PAYLOAD  = 4'd6,
    CK_A     = 4'd7,
    CK_B     = 4'd8
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  class_reg, class_reg_next;
  logic [7:0]  ident_reg, ident_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] count_reg, count_reg_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;

  logic [7:0]  acc_a;
  logic [7:0]  acc_b;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  phase_t      hunt_phase;

  assign acc_a      = sum_a + rx_byte;
  assign acc_b      = sum_b + acc_a;
  assign len_full   = {rx_byte, length_reg[7:0]};
  assign count_inc  = count_reg + 16'd1;
  assign hunt_phase = (rx_byte == cfg.sync_first) ? SYNC2 : HUNT;

  always_comb begin
    phase_next      = phase;
    class_reg_next  = class_reg;
    ident_reg_next  = ident_reg;
    length_reg_next = length_reg;
    count_reg_next  = count_reg;
    sum_a_next      = sum_a;
    sum_b_next      = sum_b;
    res_valid           = 1'b0;
    res.event_kind      = EVT_PAYLOAD;
    res.msg_cls         = class_reg;
    res.msg_ident       = ident_reg;
    res.frame_length    = length_reg;
    res.byte_index      = '0;
    res.payload_value   = '0;
    res.frame_last      = 1'b0;

    unique case (phase)
      SYNC2: begin
        phase_next = (rx_byte == cfg.sync_second) ? CLASS : hunt_phase;
      end
      CLASS: begin
        class_reg_next = rx_byte;
        sum_a_next     = rx_byte;
        sum_b_next     = rx_byte;
        phase_next     = IDENT;
      end
      IDENT: begin
        sum_a_next     = acc_a;
        sum_b_next     = acc_b;
        ident_reg_next = rx_byte;
        phase_next     = LEN_LO;
      end
      LEN_LO: begin
        sum_a_next      = acc_a;
        sum_b_next      = acc_b;
        length_reg_next = {8'd0, rx_byte};
        phase_next      = LEN_HI;
      end
      LEN_HI: begin
        sum_a_next = acc_a;
        sum_b_next = acc_b;
        if (len_full > cfg.max_payload) begin
          length_reg_next  = '0;
          phase_next       = hunt_phase;
          res_valid        = 1'b1;
          res.event_kind   = EVT_LEN_REJ;
          res.frame_length = len_full;
          res.frame_last   = 1'b1;
        end else begin
          length_reg_next = len_full;
          count_reg_next  = '0;
          phase_next      = (len_full == 16'd0) ? CK_A : PAYLOAD;
        end
      end
      PAYLOAD: begin
        sum_a_next        = acc_a;
        sum_b_next        = acc_b;
        count_reg_next    = count_inc;
        if (count_inc == length_reg) phase_next = CK_A;
        res_valid         = 1'b1;
        res.byte_index    = count_reg;
        res.payload_value = rx_byte;
      end
      CK_A: begin
        if (rx_byte != sum_a) begin
          phase_next     = hunt_phase;
          res_valid      = 1'b1;
          res.event_kind = EVT_BAD_SUM;
          res.frame_last = 1'b1;
        end else begin
          phase_next = CK_B;
        end
      end
      CK_B: begin
        phase_next     = HUNT;
        res_valid      = 1'b1;
        res.event_kind = (rx_byte == sum_b) ? EVT_GOOD : EVT_BAD_SUM;
        res.frame_last = 1'b1;
      end
      default: begin
        phase_next = hunt_phase;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= HUNT;
      class_reg  <= '0;
      ident_reg  <= '0;
      length_reg <= '0;
      count_reg  <= '0;
      sum_a      <= '0;
      sum_b      <= '0;
    end else if (step) begin
      phase      <= phase_next;
      class_reg  <= class_reg_next;
      ident_reg  <= ident_reg_next;
      length_reg <= length_reg_next;
      count_reg  <= count_reg_next;
      sum_a      <= sum_a_next;
      sum_b      <= sum_b_next;
    end
  end

endmodule

[hdl/ubxp_out_buf.sv]
// Output register with skid stage between parser core and event channel.
`timescale 1ns / 1ps

module ubxp_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           res_valid,
  input  ubxp_pkg::evt_t res,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output ubxp_pkg::evt_t out_data
);
  import ubxp_pkg::*;

  logic skid_valid;
  evt_t skid_data;
  logic pop;
  logic push;

  assign in_ready = !skid_valid;
  assign pop      = out_valid && out_ready;
  assign push     = step && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        if (push) out_data <= res;
      end
    end else if (!out_valid) begin
      out_valid <= push;
      if (push) out_data <= res;
    end else if (push) begin
      skid_data  <= res;
      skid_valid <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a pending output");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !step)
    else $error("request taken while skid stage full");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (out_valid && !skid_valid))
    else $error("skid entry not moved to output after pop");
`endif

endmodule

[hdl/ubx_frame_parser.sv]
// Top level of the binary GPS frame parser.
`timescale 1ns / 1ps

// Takes one received byte per request on rx and frames messages: two sync
// bytes, class, id, 16-bit little-endian length, payload, then a two-byte
// 8-bit Fletcher checksum over class through payload. Each payload byte gives
// one event with its index; each frame ends in one verdict event (good, bad
// checksum, length rejected) with frame_last set. Bytes are taken one per clock
// while rx.ready is high: each byte updates the frame state in the cycle it is
// accepted and its event, if any, is registered for the evt channel. A
// two-entry output buffer (register plus skid stage) lets rx keep flowing while
// one event waits on evt; rx.ready drops only when both entries are full. Sync
// values and the payload length limit are set through the APB port (0x0, 0x4,
// 0x8); the user must write them only while idle; the block does not check.
module ubx_frame_parser (
  input  logic                            clk,
  input  logic                            rst,
  ubxp_rx_if.sink                         rx,
  ubxp_evt_if.source                      evt,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ubxp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ubxp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ubxp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import ubxp_pkg::*;

  cfg_t cfg;
  logic step;
  logic res_valid;
  evt_t res;
  logic in_ready;
  evt_t out_data;

  assign rx.ready = in_ready;
  assign step     = rx.valid && in_ready;

  ubxp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ubxp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .rx_byte   (rx.rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  ubxp_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .in_ready  (in_ready),
    .out_valid (evt.valid),
    .out_ready (evt.ready),
    .out_data  (out_data)
  );

  assign evt.event_kind    = out_data.event_kind;
  assign evt.msg_cls       = out_data.msg_cls;
  assign evt.msg_ident     = out_data.msg_ident;
  assign evt.frame_length  = out_data.frame_length;
  assign evt.byte_index    = out_data.byte_index;
  assign evt.payload_value = out_data.payload_value;
  assign evt.frame_last    = out_data.frame_last;

endmodule

[sim/ubxp_event_checker.sv]
// Checker for the frame parser: tracks frame state per byte and compares events in order.
`timescale 1ns / 1ps

module ubxp_event_checker (
  input  logic                            clk,
  input  logic                            rst,
  ubxp_rx_if                              rx,
  ubxp_evt_if                             evt,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [ubxp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ubxp_pkg::CFG_DATA_W-1:0] pwdata,
  output int                              fail_count,
  output int                              pending
);

  import ubxp_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT, PH_SYNC2, PH_CLASS, PH_IDENT, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_SUM_A, PH_SUM_B
  } phase_e;

  cfg_t        cfg;
  phase_e      phase;
  logic [7:0]  cls_q;
  logic [7:0]  ident_q;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [15:0] len_q;
  logic [15:0] count_q;
  evt_t        expected_events[$];
  int          fails = 0;

  function automatic void hunt_on(input logic [7:0] b);
    phase = (b == cfg.sync_first) ? PH_SYNC2 : PH_HUNT;
  endfunction

  function automatic void fold(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  function automatic void post(input logic [1:0] kind, input logic [15:0] len,
                               input logic [15:0] idx, input logic [7:0] val, input logic last);
    evt_t e;
    e.event_kind    = kind;
    e.msg_cls       = cls_q;
    e.msg_ident     = ident_q;
    e.frame_length  = len;
    e.byte_index    = idx;
    e.payload_value = val;
    e.frame_last    = last;
    expected_events.push_back(e);
  endfunction

  function automatic string show(input evt_t e);
    return $sformatf("kind=%0d class=%h id=%h len=%0d idx=%0d val=%h last=%0b",
                     e.event_kind, e.msg_cls, e.msg_ident, e.frame_length,
                     e.byte_index, e.payload_value, e.frame_last);
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    case (phase)
      PH_SYNC2: begin
        if (b == cfg.sync_second) phase = PH_CLASS;
        else hunt_on(b);
      end
      PH_CLASS: begin
        cls_q = b;
        sum_a = b;
        sum_b = b;
        phase = PH_IDENT;
      end
      PH_IDENT: begin
        fold(b);
        ident_q = b;
        phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        fold(b);
        len_q = {8'h00, b};
        phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        fold(b);
        len_q[15:8] = b;
        if (len_q > cfg.max_payload) begin
          post(EVT_LEN_REJ, len_q, 16'd0, 8'd0, 1'b1);
          len_q = '0;
          hunt_on(b);
        end else begin
          count_q = '0;
          phase = (len_q == 16'd0) ? PH_SUM_A : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        fold(b);
        post(EVT_PAYLOAD, len_q, count_q, b, 1'b0);
        count_q = count_q + 16'd1;
        if (count_q == len_q) phase = PH_SUM_A;
      end
      PH_SUM_A: begin
        if (b != sum_a) begin
          post(EVT_BAD_SUM, len_q, 16'd0, 8'd0, 1'b1);
          hunt_on(b);
        end else begin
          phase = PH_SUM_B;
        end
      end
      PH_SUM_B: begin
        phase = PH_HUNT;
        post((b == sum_b) ? EVT_GOOD : EVT_BAD_SUM, len_q, 16'd0, 8'd0, 1'b1);
      end
      default: hunt_on(b);
    endcase
  endfunction

  always @(posedge clk) begin : watch
    evt_t got;
    evt_t want;
    if (rst) begin
      cfg.sync_first  = SYNC_FIRST_RST;
      cfg.sync_second = SYNC_SECOND_RST;
      cfg.max_payload = MAX_PAYLOAD_RST;
      phase   = PH_HUNT;
      cls_q   = '0;
      ident_q = '0;
      len_q   = '0;
      count_q = '0;
      sum_a   = '0;
      sum_b   = '0;
      expected_events.delete();
    end else begin
      // events leave before this edge's byte can produce one
      if (evt.valid && evt.ready) begin
        got = {evt.event_kind, evt.msg_cls, evt.msg_ident, evt.frame_length,
               evt.byte_index, evt.payload_value, evt.frame_last};
        if (expected_events.size() == 0) begin
          fails++;
          $display("%t: unexpected event: expected none, got %s", $time, show(got));
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            fails++;
            $display("%t: event mismatch: expected %s, got %s", $time, show(want), show(got));
          end
        end
      end
      if (rx.valid && rx.ready) parse_byte(rx.rx_byte);
      if (psel && penable && pwrite && pready) begin
        case (paddr[ubxp_pkg::CFG_ADDR_W-1:2])
          REG_SYNC_FIRST:  cfg.sync_first  = pwdata[7:0];
          REG_SYNC_SECOND: cfg.sync_second = pwdata[7:0];
          REG_MAX_PAYLOAD: cfg.max_payload = pwdata[15:0];
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    pending    <= expected_events.size();
  end

endmodule

[sim/tb_ubx_frame_parser.sv]
// Testbench top for the frame parser: frame stimulus, config phases, stalls and verdict.
`timescale 1ns / 1ps

module tb_ubx_frame_parser;

  import ubxp_pkg::*;

  typedef enum {FRAME_OK, BAD_SYNC2, LEN_OVER, BAD_SUM_A, BAD_SUM_B} frame_fault_e;
  typedef enum {SINK_OPEN, SINK_COIN, SINK_QUARTER, SINK_SPARSE} sink_mode_e;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;

  cfg_t       cur_cfg;
  int         burst_left = 0;
  bit         steady = 1'b0;
  int         bytes_sent = 0;
  int         noise_sent = 0;
  logic [15:0] sink_tick = '0;
  sink_mode_e sink_mode = SINK_OPEN;

  ubxp_rx_if  rx_ch ();
  ubxp_evt_if evt_ch ();

  ubx_frame_parser uut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .evt     (evt_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ubxp_event_checker event_check (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_ch),
    .evt        (evt_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb_ubx_frame_parser failed");
    $finish;
  end

  // event receiver: stall pattern is redrawn at random from four modes as sink_tick runs
  always @(posedge clk) begin
    sink_tick <= sink_tick + 16'd1;
    if (sink_tick % 300 == 299) sink_mode <= sink_mode_e'($urandom_range(0, 3));
    case (sink_mode)
      SINK_OPEN:    evt_ch.ready <= 1'b1;
      SINK_COIN:    evt_ch.ready <= 1'($urandom_range(0, 1));
      SINK_QUARTER: evt_ch.ready <= (sink_tick[1:0] == 2'd0);
      default:      evt_ch.ready <= (sink_tick[3:0] < 4'd3);
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      if (gap > 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  // resync: offending byte is the first sync where possible; it hunts anew except at CK_B
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] ident,
                            input logic [15:0] len, input frame_fault_e fault, input bit resync);
    logic [7:0] a;
    logic [7:0] b2;
    logic [7:0] v;
    logic [7:0] bad;
    send_byte(cur_cfg.sync_first);
    if (fault == BAD_SYNC2) begin
      do bad = 8'($urandom); while (bad == cur_cfg.sync_second || bad == cur_cfg.sync_first);
      if (resync) bad = cur_cfg.sync_first;
      send_byte(bad);
      return;
    end
    if (fault == LEN_OVER) begin
      if (resync && {cur_cfg.sync_first, len[7:0]} > cur_cfg.max_payload)
        len[15:8] = cur_cfg.sync_first;
      else if (!resync && len[15:8] == cur_cfg.sync_first)
        len[15:8] = (cur_cfg.sync_first == 8'hFF) ? 8'hFE : 8'hFF;
    end
    send_byte(cur_cfg.sync_second);
    a  = cls;
    b2 = cls;
    send_byte(cls);
    a += ident;
    b2 += a;
    send_byte(ident);
    a += len[7:0];
    b2 += a;
    send_byte(len[7:0]);
    a += len[15:8];
    b2 += a;
    send_byte(len[15:8]);
    if (fault == LEN_OVER) return;
    for (int i = 0; i < len; i++) begin
      v = 8'($urandom);
      a += v;
      b2 += a;
      send_byte(v);
    end
    if (fault == BAD_SUM_A) begin
      do bad = 8'($urandom); while (bad == a || bad == cur_cfg.sync_first);
      if (resync && cur_cfg.sync_first != a) bad = cur_cfg.sync_first;
      send_byte(bad);
      return;
    end
    send_byte(a);
    if (fault == BAD_SUM_B) begin
      do bad = 8'($urandom); while (bad == b2);
      if (resync && cur_cfg.sync_first != b2) bad = cur_cfg.sync_first;
      send_byte(bad);
    end else begin
      send_byte(b2);
    end
  endtask

  // line noise never holds a stray first sync byte except as the last one
  task automatic send_noise();
    int n;
    logic [7:0] v;
    bit distinct;
    distinct = (cur_cfg.sync_first != cur_cfg.sync_second);
    n = $urandom_range(1, 6);
    if (distinct && $urandom_range(0, 3) == 0) begin
      send_byte(cur_cfg.sync_second);
      noise_sent++;
    end
    repeat (n) begin
      v = 8'($urandom);
      if (v == cur_cfg.sync_first) v = ~v;
      send_byte(v);
      noise_sent++;
    end
    if (distinct && $urandom_range(0, 1) == 0) begin
      send_byte(cur_cfg.sync_first);
      noise_sent++;
    end
  endtask

  task automatic random_traffic(input int goal);
    int r;
    int k;
    int l;
    frame_fault_e f;
    bit resync;
    while (bytes_sent - noise_sent < goal) begin
      r = $urandom_range(0, 99);
      resync = (cur_cfg.sync_first != cur_cfg.sync_second) && ($urandom_range(0, 2) == 0);
      if (r >= 93) begin
        send_noise();
      end else if (r >= 83 && cur_cfg.max_payload != 16'hFFFF) begin
        l = ($urandom_range(0, 3) == 0) ? 65535 :
            $urandom_range(cur_cfg.max_payload + 1, 65535);
        send_frame(8'($urandom), 8'($urandom), 16'(l), LEN_OVER, resync);
      end else begin
        f = (r < 55 || r >= 83) ? FRAME_OK : (r < 65) ? BAD_SUM_A :
            (r < 75) ? BAD_SUM_B : BAD_SYNC2;
        k = $urandom_range(0, 49);
        if (k == 0) l = $urandom_range(0, 300);
        else if (k < 6) l = $urandom_range(9, 64);
        else l = $urandom_range(0, 8);
        if (l > cur_cfg.max_payload) l = cur_cfg.max_payload;
        send_frame(8'($urandom), 8'($urandom), 16'(l), f, resync);
      end
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [7:0] s1, input logic [7:0] s2, input logic [15:0] mx);
    cfg_write(REG_SYNC_FIRST, CFG_DATA_W'(s1));
    cfg_write(REG_SYNC_SECOND, CFG_DATA_W'(s2));
    cfg_write(REG_MAX_PAYLOAD, CFG_DATA_W'(mx));
    cur_cfg.sync_first  = s1;
    cur_cfg.sync_second = s2;
    cur_cfg.max_payload = mx;
  endtask

  // hold the sender until every request has produced its events
  task automatic settle();
    rx_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [7:0] s1;
    logic [7:0] s2;
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    cur_cfg.sync_first  = SYNC_FIRST_RST;
    cur_cfg.sync_second = SYNC_SECOND_RST;
    cur_cfg.max_payload = MAX_PAYLOAD_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_frame(8'h00, 8'h00, 16'd0, FRAME_OK, 1'b0);
    send_frame(8'hFF, 8'hFF, 16'd0, BAD_SUM_B, 1'b1);
    // second sync right after a bad second checksum must not open a frame
    send_byte(cur_cfg.sync_second);
    send_frame(8'h03, 8'h04, 16'h00FF, LEN_OVER, 1'b1);
    send_frame(8'h05, 8'h06, 16'd1, BAD_SUM_A, 1'b1);
    send_frame(8'h07, 8'h08, 16'd0, BAD_SYNC2, 1'b1);

    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: apply_config(8'h00, 8'hFF, 16'd0);
        1: apply_config(8'h55, 8'h55, 16'd16);
        2: apply_config(8'hFF, 8'h00, 16'hFFFF);
        3: begin
          s1 = 8'($urandom);
          do s2 = 8'($urandom); while (s2 == s1);
          apply_config(s1, s2, 16'($urandom_range(1, 600)));
        end
        default: apply_config(SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_PAYLOAD_RST);
      endcase
      steady = (p == 2);
      random_traffic(bytes_sent - noise_sent + 280);
    end

    settle();
    if (fail_count == 0) $display("tb_ubx_frame_parser passed");
    else $display("tb_ubx_frame_parser failed");
    $finish;
  end

endmodule

[ubx_frame_parser.f]
hdl/ubxp_pkg.sv
hdl/ubxp_ifs.sv
hdl/ubxp_cfg_regs.sv
hdl/ubxp_core.sv
hdl/ubxp_out_buf.sv
hdl/ubx_frame_parser.sv
sim/ubxp_event_checker.sv
sim/tb_ubx_frame_parser.sv
